/* hw/rtl/double_talk_detector_unit_macros.svh */
// Assertion macros used by the checker file of the double-talk detector.
`ifndef DOUBLE_TALK_DETECTOR_UNIT_MACROS_SVH
`define DOUBLE_TALK_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DTD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after a reset edge.
`define DTD_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dtd_pkg.sv */
`default_nettype none

package dtd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SQ_W        = 31;
   localparam int SUM_W       = 42;
   localparam int LVL_W       = 32;
   localparam int ALPHA_W     = 16;
   localparam int RATIO_W     = 16;
   localparam int SILENCE_W   = 24;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int QDEPTH      = 2;
   localparam int LEVEL_W     = $clog2(QDEPTH + 1);

   localparam int DEF_MAX_FRAME_SAMPLES = 1024;

   localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 16'd58982;
   localparam logic [RATIO_W-1:0]   RATIO_RESET   = 16'd128;
   localparam logic [SILENCE_W-1:0] SILENCE_RESET = 24'd11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA   = 2'd0,
      CSR_RATIO   = 2'd1,
      CSR_SILENCE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      TALK_SILENCE   = 2'd0,
      TALK_FAR_ONLY  = 2'd1,
      TALK_NEAR_ONLY = 2'd2,
      TALK_DOUBLE    = 2'd3
   } talk_state_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]   alpha;
      logic [RATIO_W-1:0]   ratio_threshold;
      logic [SILENCE_W-1:0] silence_threshold;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/dtd_if.sv */
`default_nettype none

interface dtd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] far_sample;
   logic signed [15:0] mic_sample;
   logic               frame_end;

   modport source (output valid, output far_sample, output mic_sample, output frame_end,
                   input ready);
   modport sink   (input valid, input far_sample, input mic_sample, input frame_end,
                   output ready);
endinterface

interface dtd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] talk_state;
   logic       adapt_hold;

   modport source (output valid, output talk_state, output adapt_hold, input ready);
   modport sink   (input valid, input talk_state, input adapt_hold, output ready);
endinterface

`default_nettype wire

/* hw/rtl/double_talk_detector_unit.sv */
// Energy-ratio double-talk detector.
// req_channel carries one far-end / microphone sample pair (signed Q15) per
// transfer, with frame_end marking the last pair of a frame. rsp_channel
// carries one result per frame: talk_state and adapt_hold.
// The csr_ port writes the smoothing weight, the ratio threshold and the
// silence threshold; write them only while no frame is in flight.
// Samples are taken at one pair per cycle while req ready is high. A frame
// end enters a two-entry queue; the back end then runs a one-bit-per-cycle
// divider over the 42-bit energy sums and five steps on a shared
// multiplier. Frames that arrive faster than the back end finishes them
// therefore run at the back end's pace once the queue is full.
// Reset clears the energy sums, the sample count and the smoothed powers,
// and restores the register defaults; req ready is high right after reset.
// A stalled rsp_channel holds its result; the back end waits with the next
// one, the queue fills, and then req ready drops.

`default_nettype none

module double_talk_detector_unit import dtd_pkg::*; #(
   parameter int MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dtd_req_if.sink                    req_channel,
   dtd_rsp_if.source                  rsp_channel,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int DIV_W   = $clog2(MAX_FRAME_SAMPLES + 2);
   localparam int ENTRY_W = 2 * SUM_W + DIV_W;

   cfg_type            cfg_ff, cfg_in;
   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic               pop_valid;
   logic [ENTRY_W-1:0] pop_data;
   logic [LEVEL_W-1:0] q_level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ALPHA:   cfg_in.alpha             = csr_write_data[ALPHA_W-1:0];
            CSR_RATIO:   cfg_in.ratio_threshold   = csr_write_data[RATIO_W-1:0];
            CSR_SILENCE: cfg_in.silence_threshold = csr_write_data[SILENCE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha             <= ALPHA_RESET;
         cfg_ff.ratio_threshold   <= RATIO_RESET;
         cfg_ff.silence_threshold <= SILENCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtd_front #(
      .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_channel),
      .q_level   (q_level),
      .push      (push),
      .push_data (push_data)
   );

   dtd_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .level     (q_level)
   );

   dtd_back #(
      .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (pop_valid),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp     (rsp_channel)
   );

endmodule

`default_nettype wire

/* hw/rtl/dtd_queue.sv */
`default_nettype none

module dtd_queue import dtd_pkg::*; #(
   parameter int DATA_W = 2 * SUM_W + 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic                   pop_valid,
   output logic [DATA_W-1:0]      pop_data,
   output logic [LEVEL_W-1:0]     level
);

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   logic [DATA_W-1:0]  mem_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               do_pop;

   assign pop_valid = (level_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (!push && do_pop) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/dtd_front.sv */
`default_nettype none

module dtd_front import dtd_pkg::*; #(
   parameter int MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES,
   localparam int DIV_W   = $clog2(MAX_FRAME_SAMPLES + 2),
   localparam int ENTRY_W = 2 * SUM_W + DIV_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   dtd_req_if.sink           req,
   input  wire logic [LEVEL_W-1:0] q_level,
   output logic              push,
   output logic [ENTRY_W-1:0] push_data
);

   localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME_SAMPLES - 1);

   function automatic logic [SQ_W-1:0] square_q15(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] mag;
      mag = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
      return SQ_W'({16'b0, mag} * {16'b0, mag});
   endfunction

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_last_ff, s1_last_in;
   logic [SQ_W-1:0]    s1_far_sq_ff, s1_far_sq_in;
   logic [SQ_W-1:0]    s1_mic_sq_ff, s1_mic_sq_in;
   logic [DIV_W-1:0]   s1_div_ff, s1_div_in;
   logic [SUM_W-1:0]   far_sum_ff, far_sum_in;
   logic [SUM_W-1:0]   mic_sum_ff, mic_sum_in;
   logic [SUM_W-1:0]   far_next, mic_next;
   logic [LEVEL_W:0]   need;
   logic               accept;
   logic               keep;

   // A frame end still in the square stage will take a queue slot next cycle.
   assign need      = {1'b0, q_level} + {{LEVEL_W{1'b0}}, s1_valid_ff && s1_last_ff};
   assign req.ready = (need < (LEVEL_W + 1)'(QDEPTH));
   assign accept    = req.valid && req.ready;
   assign keep      = req.frame_end || (cnt_ff < CNT_LIMIT);

   assign far_next  = far_sum_ff + SUM_W'(s1_far_sq_ff);
   assign mic_next  = mic_sum_ff + SUM_W'(s1_mic_sq_ff);
   assign push      = s1_valid_ff && s1_last_ff;
   assign push_data = {far_next, mic_next, s1_div_ff};

   always_comb begin
      cnt_in       = cnt_ff;
      s1_valid_in  = accept && keep;
      s1_last_in   = req.frame_end;
      s1_far_sq_in = square_q15(req.far_sample);
      s1_mic_sq_in = square_q15(req.mic_sample);
      s1_div_in    = DIV_W'(cnt_ff) + DIV_W'(2);
      if (accept) begin
         if (req.frame_end) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      far_sum_in = far_sum_ff;
      mic_sum_in = mic_sum_ff;
      if (s1_valid_ff) begin
         far_sum_in = s1_last_ff ? '0 : far_next;
         mic_sum_in = s1_last_ff ? '0 : mic_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         far_sum_ff  <= '0;
         mic_sum_ff  <= '0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         far_sum_ff  <= far_sum_in;
         mic_sum_ff  <= mic_sum_in;
      end
      s1_last_ff   <= s1_last_in;
      s1_far_sq_ff <= s1_far_sq_in;
      s1_mic_sq_ff <= s1_mic_sq_in;
      s1_div_ff    <= s1_div_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/dtd_back.sv */
`default_nettype none

module dtd_back import dtd_pkg::*; #(
   parameter int MAX_FRAME_SAMPLES = DEF_MAX_FRAME_SAMPLES,
   localparam int DIV_W   = $clog2(MAX_FRAME_SAMPLES + 2),
   localparam int ENTRY_W = 2 * SUM_W + DIV_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               q_valid,
   input  wire logic [ENTRY_W-1:0] q_data,
   output logic                    q_pop,
   dtd_rsp_if.source               rsp
);

   localparam int BIT_CNT_W = $clog2(SUM_W);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(SUM_W - 1);
   localparam int MUL_A_W = ALPHA_W + 1;
   localparam int PROD_W  = MUL_A_W + SUM_W;
   localparam int ACC_W   = LVL_W + 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FAR_OLD,
      ST_FAR_NEW,
      ST_MIC_OLD,
      ST_MIC_NEW,
      ST_RATIO,
      ST_DECIDE
   } state_type;

   state_type            state_ff, state_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [SUM_W-1:0]     far_quo_ff, far_quo_in;
   logic [SUM_W-1:0]     mic_quo_ff, mic_quo_in;
   logic [DIV_W-1:0]     far_rem_ff, far_rem_in;
   logic [DIV_W-1:0]     mic_rem_ff, mic_rem_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [LVL_W-1:0]     far_lvl_ff, far_lvl_in;
   logic [LVL_W-1:0]     mic_lvl_ff, mic_lvl_in;
   logic                 out_valid_ff, out_valid_in;
   talk_state_type       talk_ff, talk_in;
   logic                 frozen_ff, frozen_in;

   logic [DIV_W:0]       far_trial, mic_trial;
   logic                 far_ge, mic_ge;
   logic [MUL_A_W-1:0]   mul_a;
   logic [SUM_W-1:0]     mul_b;
   logic [MUL_A_W-1:0]   one_minus_alpha;
   logic [ACC_W-1:0]     smooth_sum;
   logic [LVL_W-1:0]     smooth_lvl;
   logic                 far_on, mic_on, ratio_hit;
   logic                 emit;

   assign far_trial       = {far_rem_ff, far_quo_ff[SUM_W-1]};
   assign mic_trial       = {mic_rem_ff, mic_quo_ff[SUM_W-1]};
   assign far_ge          = (far_trial >= {1'b0, div_ff});
   assign mic_ge          = (mic_trial >= {1'b0, div_ff});
   assign one_minus_alpha = MUL_A_W'(1 << ALPHA_W) - {1'b0, cfg.alpha};
   assign smooth_sum      = acc_ff + prod_ff[ACC_W-1:0];
   assign smooth_lvl      = smooth_sum[ACC_W-1:16];

   assign far_on    = (far_lvl_ff > LVL_W'(cfg.silence_threshold));
   assign mic_on    = (mic_lvl_ff > LVL_W'(cfg.silence_threshold));
   assign ratio_hit = (PROD_W'({mic_lvl_ff, 8'b0}) > prod_ff);
   assign emit      = (state_ff == ST_DECIDE) && (!out_valid_ff || rsp.ready);

   assign q_pop          = (state_ff == ST_IDLE) && q_valid;
   assign rsp.valid      = out_valid_ff;
   assign rsp.talk_state = talk_ff;
   assign rsp.adapt_hold = frozen_ff;

   always_comb begin
      case (state_ff)
         ST_FAR_OLD: begin
            mul_a = {1'b0, cfg.alpha};
            mul_b = SUM_W'(far_lvl_ff);
         end
         ST_FAR_NEW: begin
            mul_a = one_minus_alpha;
            mul_b = far_quo_ff;
         end
         ST_MIC_OLD: begin
            mul_a = {1'b0, cfg.alpha};
            mul_b = SUM_W'(mic_lvl_ff);
         end
         ST_MIC_NEW: begin
            mul_a = one_minus_alpha;
            mul_b = mic_quo_ff;
         end
         ST_RATIO: begin
            mul_a = {1'b0, cfg.ratio_threshold};
            mul_b = SUM_W'(far_lvl_ff) + SUM_W'(1);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      far_quo_in   = far_quo_ff;
      mic_quo_in   = mic_quo_ff;
      far_rem_in   = far_rem_ff;
      mic_rem_in   = mic_rem_ff;
      div_in       = div_ff;
      prod_in      = PROD_W'(mul_a) * PROD_W'(mul_b);
      acc_in       = acc_ff;
      far_lvl_in   = far_lvl_ff;
      mic_lvl_in   = mic_lvl_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      talk_in      = talk_ff;
      frozen_in    = frozen_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               far_quo_in = q_data[ENTRY_W-1 -: SUM_W];
               mic_quo_in = q_data[DIV_W +: SUM_W];
               div_in     = q_data[DIV_W-1:0];
               far_rem_in = '0;
               mic_rem_in = '0;
               bit_cnt_in = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            far_rem_in = far_ge ? DIV_W'(far_trial - {1'b0, div_ff}) : DIV_W'(far_trial);
            mic_rem_in = mic_ge ? DIV_W'(mic_trial - {1'b0, div_ff}) : DIV_W'(mic_trial);
            far_quo_in = {far_quo_ff[SUM_W-2:0], far_ge};
            mic_quo_in = {mic_quo_ff[SUM_W-2:0], mic_ge};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = ST_FAR_OLD;
            end
         end
         ST_FAR_OLD: begin
            state_in = ST_FAR_NEW;
         end
         ST_FAR_NEW: begin
            acc_in   = prod_ff[ACC_W-1:0];
            state_in = ST_MIC_OLD;
         end
         ST_MIC_OLD: begin
            far_lvl_in = smooth_lvl;
            state_in   = ST_MIC_NEW;
         end
         ST_MIC_NEW: begin
            acc_in   = prod_ff[ACC_W-1:0];
            state_in = ST_RATIO;
         end
         ST_RATIO: begin
            mic_lvl_in = smooth_lvl;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            prod_in = prod_ff;
            if (emit) begin
               if (far_on && mic_on) begin
                  talk_in = ratio_hit ? TALK_DOUBLE : TALK_FAR_ONLY;
               end else if (far_on) begin
                  talk_in = TALK_FAR_ONLY;
               end else if (mic_on) begin
                  talk_in = TALK_NEAR_ONLY;
               end else begin
                  talk_in = TALK_SILENCE;
               end
               frozen_in    = mic_on && (!far_on || ratio_hit);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         far_lvl_ff   <= '0;
         mic_lvl_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         far_lvl_ff   <= far_lvl_in;
         mic_lvl_ff   <= mic_lvl_in;
         out_valid_ff <= out_valid_in;
      end
      bit_cnt_ff <= bit_cnt_in;
      far_quo_ff <= far_quo_in;
      mic_quo_ff <= mic_quo_in;
      far_rem_ff <= far_rem_in;
      mic_rem_ff <= mic_rem_in;
      div_ff     <= div_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      talk_ff    <= talk_in;
      frozen_ff  <= frozen_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/dtd_checker.sv */
`default_nettype none

`include "double_talk_detector_unit_macros.svh"

module dtd_checker import dtd_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] talk_state,
   input wire logic       adapt_hold
);

   `DTD_ASSERT_RST(a_ready_after_reset, req_ready, "input not ready after reset")
   `DTD_ASSERT_RST(a_no_result_after_reset, !rsp_valid, "result present after reset")
   `DTD_ASSERT_IMP(a_frozen_matches_state, rsp_valid, adapt_hold == (talk_state == TALK_NEAR_ONLY || talk_state == TALK_DOUBLE), "freeze flag disagrees with talk state")
   `DTD_ASSERT_NXT(a_result_held, rsp_valid && !rsp_ready, rsp_valid && $stable(talk_state) && $stable(adapt_hold), "stalled result changed")
   `DTD_ASSERT_NXT(a_request_held, req_valid && !req_ready, req_valid, "stalled request withdrawn")

endmodule

bind double_talk_detector_unit dtd_checker u_dtd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_channel.valid),
   .req_ready  (req_channel.ready),
   .rsp_valid  (rsp_channel.valid),
   .rsp_ready  (rsp_channel.ready),
   .talk_state (rsp_channel.talk_state),
   .adapt_hold (rsp_channel.adapt_hold)
);

`default_nettype wire

/* tb/sv/double_talk_detector_unit_tb.sv */
module double_talk_detector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dtd_pkg::*;

   localparam int unsigned NUM_PHASES      = 6;
   localparam int unsigned PHASE_PAIRS     = 100;
   localparam int unsigned IDLE_PERCENT    = 35;
   localparam int unsigned SETTLE_CYCLES   = 64;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;

   typedef struct packed {
      talk_state_type talk_state;
      logic           adapt_hold;
   } talk_verdict_type;

   class talk_tracker_type;
      logic [ALPHA_W-1:0]   alpha;
      logic [RATIO_W-1:0]   ratio;
      logic [SILENCE_W-1:0] silence;
      longint unsigned      far_sum;
      longint unsigned      mic_sum;
      int unsigned          pairs;
      logic [LVL_W-1:0]     far_lvl;
      logic [LVL_W-1:0]     mic_lvl;
      int unsigned          frame_cap;
      talk_verdict_type     verdicts[$];
      int unsigned          errors;

      function new(int unsigned cap);
         frame_cap = cap;
         alpha     = ALPHA_RESET;
         ratio     = RATIO_RESET;
         silence   = SILENCE_RESET;
         far_sum   = 0;
         mic_sum   = 0;
         pairs     = 0;
         far_lvl   = '0;
         mic_lvl   = '0;
         errors    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ALPHA:   alpha   = data[ALPHA_W-1:0];
            CSR_RATIO:   ratio   = data[RATIO_W-1:0];
            CSR_SILENCE: silence = data[SILENCE_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned energy(logic signed [SAMPLE_W-1:0] s);
         longint unsigned mag;
         mag = (s < 0) ? 64'(-int'(s)) : 64'(int'(s));
         return mag * mag;
      endfunction

      function logic [LVL_W-1:0] blend(logic [LVL_W-1:0] lvl, longint unsigned p);
         longint unsigned acc;
         acc = 64'(alpha) * 64'(lvl) + (64'd65536 - 64'(alpha)) * p;
         return acc[47:16];
      endfunction

      function void take_pair(logic signed [SAMPLE_W-1:0] far, logic signed [SAMPLE_W-1:0] mic,
                              logic last);
         longint unsigned n;
         talk_state_type  st;
         logic            far_on;
         logic            mic_on;
         if (!last) begin
            // Pairs beyond the frame capacity are dropped until the frame end arrives.
            if (pairs < frame_cap - 1) begin
               far_sum += energy(far);
               mic_sum += energy(mic);
               pairs++;
            end
            return;
         end
         far_sum += energy(far);
         mic_sum += energy(mic);
         n = 64'(pairs) + 1;
         far_lvl = blend(far_lvl, far_sum / (n + 1));
         mic_lvl = blend(mic_lvl, mic_sum / (n + 1));
         far_sum = 0;
         mic_sum = 0;
         pairs   = 0;
         far_on  = far_lvl > 32'(silence);
         mic_on  = mic_lvl > 32'(silence);
         if (far_on && mic_on) begin
            st = (64'(mic_lvl) * 64'd256 > 64'(ratio) * (64'(far_lvl) + 64'd1)) ?
                 TALK_DOUBLE : TALK_FAR_ONLY;
         end else if (far_on) begin
            st = TALK_FAR_ONLY;
         end else if (mic_on) begin
            st = TALK_NEAR_ONLY;
         end else begin
            st = TALK_SILENCE;
         end
         verdicts.push_back('{talk_state: st,
                              adapt_hold: (st == TALK_NEAR_ONLY || st == TALK_DOUBLE)});
      endfunction

      function int unsigned outstanding();
         return verdicts.size();
      endfunction

      function void check_result(logic [1:0] st, logic frozen);
         talk_verdict_type want;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected result, talk_state %0d adapt_hold %0d",
                     $time, st, frozen);
            errors++;
            return;
         end
         want = verdicts.pop_front();
         if (st !== want.talk_state) begin
            $display("%0t: talk_state expected %0d, actual %0d", $time, want.talk_state, st);
            errors++;
         end
         if (frozen !== want.adapt_hold) begin
            $display("%0t: adapt_hold expected %0d, actual %0d",
                     $time, want.adapt_hold, frozen);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   bit                    gaps_on = 1'b1;
   int unsigned           hold_requests = 0;
   talk_tracker_type      tracker = new(DEF_MAX_FRAME_SAMPLES);

   dtd_req_if req_bus ();
   dtd_rsp_if rsp_bus ();

   double_talk_detector_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            tracker.write_reg(csr_index_type'(csr_index), csr_write_data);
         end
         if (req_bus.valid && req_bus.ready) begin
            tracker.take_pair(req_bus.far_sample, req_bus.mic_sample, req_bus.frame_end);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_result(rsp_bus.talk_state, rsp_bus.adapt_hold);
         end
      end
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[double_talk_detector_unit] ERROR");
      $finish;
   end

   // A bump of hold_requests makes the receiver refuse results for a long stretch.
   initial begin : result_sink
      int unsigned hold_left;
      int unsigned served;
      hold_left = 0;
      served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (served != hold_requests) begin
            served = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   task automatic send_pair(logic signed [SAMPLE_W-1:0] far, logic signed [SAMPLE_W-1:0] mic,
                            logic last);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.far_sample <= far;
      req_bus.mic_sample <= mic;
      req_bus.frame_end  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int unsigned span);
      if ($urandom_range(0, 31) == 0) return SAMPLE_W'($urandom);
      case (span)
         0: return '0;
         1: return SAMPLE_W'($urandom_range(0, 31) - 16);
         2: return SAMPLE_W'($urandom_range(0, 4095) - 2048);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int unsigned frame_length();
      if ($urandom_range(0, 15) == 0) return $urandom_range(40, 120);
      return $urandom_range(1, 16);
   endfunction

   task automatic send_frame(int unsigned len);
      int unsigned far_span;
      int unsigned mic_span;
      far_span = $urandom_range(0, 3);
      mic_span = $urandom_range(0, 3);
      for (int unsigned i = 0; i < len; i++) begin
         send_pair(pick_sample(far_span), pick_sample(mic_span), i == len - 1);
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_config(cfg_type cfg);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ALPHA;
      csr_write_data   <= CSR_DATA_W'(cfg.alpha);
      @(negedge clock);
      csr_index        <= CSR_RATIO;
      csr_write_data   <= CSR_DATA_W'(cfg.ratio_threshold);
      @(negedge clock);
      csr_index        <= CSR_SILENCE;
      csr_write_data   <= CSR_DATA_W'(cfg.silence_threshold);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      cfg_type     phase_cfg [NUM_PHASES];
      int unsigned sent;
      int unsigned len;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.far_sample = '0;
      req_bus.mic_sample = '0;
      req_bus.frame_end  = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_ALPHA;
      csr_write_data     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_pair(16'sd32767, -16'sd32768, 1'b0);
      send_pair(-16'sd32768, 16'sd32767, 1'b0);
      send_pair(-16'sd1, 16'sd1, 1'b1);
      settle();

      // With no smoothing each level equals the power of the frame just ended.
      write_config('{alpha: 16'd0, ratio_threshold: 16'd256, silence_threshold: 24'd11});
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd32767, 16'sd0, 1'b1);
      send_pair(16'sd0, -16'sd32768, 1'b1);
      send_pair(16'sd1000, 16'sd32767, 1'b1);
      send_pair(16'sd32767, 16'sd1000, 1'b1);
      send_pair(16'sd500, -16'sd500, 1'b1);
      send_pair(16'sd5, 16'sd5, 1'b0);
      send_pair(-16'sd3, -16'sd3, 1'b1);
      send_pair(16'sd6, 16'sd6, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b1);

      phase_cfg[0] = '{ALPHA_RESET, RATIO_RESET, SILENCE_RESET};
      phase_cfg[1] = '{16'd0, 16'd0, 24'd0};
      phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 24'hFFFFFF};
      phase_cfg[3] = '{16'($urandom), 16'($urandom), 24'($urandom_range(0, 1 << 20))};
      phase_cfg[4] = '{16'd16384, 16'd256, 24'd1 << 20};
      phase_cfg[5] = '{16'($urandom), 16'($urandom), 24'($urandom)};

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_config(phase_cfg[p]);
         gaps_on <= (p != 3);
         if (p == 1) hold_requests <= hold_requests + 1;
         sent = 0;
         if (p == 4) begin
            len = DEF_MAX_FRAME_SAMPLES + $urandom_range(1, 8);
            send_frame(len);
         end
         while (sent < PHASE_PAIRS) begin
            len = frame_length();
            send_frame(len);
            sent += len;
         end
      end
      settle();

      if (tracker.errors == 0) begin
         $display("[double_talk_detector_unit] OK");
      end else begin
         $display("[double_talk_detector_unit] ERROR");
      end
      $finish;
   end
endmodule
